>>> rtl/krt_pkg.sv
// Package for the keyed record table: sizes, record layout, operation,
// status and register codes, and sequencer states. No dependencies.
`timescale 1ns / 1ps
package krt_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 31;
  localparam int PAY_W = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } rec_t;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_SORT   = 3'd1,
    FN_REMOVE = 3'd2,
    FN_SEQ    = 3'd3,
    FN_BIN    = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_UNSORTED  = 3'd4
  } status_e;

  typedef enum logic {
    REG_ORDERED  = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_MOVE_RD,
    S_MOVE_WR,
    S_BIN_RD,
    S_BIN_CK,
    S_SORT_RD_I,
    S_SORT_GET_I,
    S_SORT_RD_J,
    S_SORT_CK_J
  } state_e;

endpackage

>>> rtl/keyed_record_table.sv
// Keyed record table: append, sort, remove and search over one record RAM.
// Depends on krt_pkg.
`timescale 1ns / 1ps
//
// Channel   | Direction | Handshake                      | Payload
// ----------+-----------+--------------------------------+-------------------------------
// command   | in        | start_i while busy_o low       | func_i, key_i, payload_i
// result    | out       | done_o, one cycle per beat     | status_o, index_o,
//           |           |                                | found_payload_o,
//           |           |                                | entry_count_out_o
// config    | in/out    | APB write on psel&penable&pwrite | paddr, pwdata, prdata
//
// Every RAM access has a read state and then a check or write state. A
// sequential search or remove visits the entries in order (and an ordered
// remove then shifts the later entries down), a binary search probes the
// middle of [lo, hi), and sort runs insertion over the RAM. busy_o is high
// from acceptance until the result beat; a full append, a refused binary
// search and an unknown func answer in the cycle after acceptance without
// raising busy_o. Reset clears the count, sets the sorted mark and the
// registers; the RAM content is undefined until written.
// Results cannot be stalled.
module keyed_record_table
  import krt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          func_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [PAY_W-1:0]    payload_i,
  output logic                done_o,
  output logic [2:0]          status_o,
  output logic [7:0]          index_o,
  output logic [PAY_W-1:0]    found_payload_o,
  output logic [8:0]          entry_count_out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // config registers
  logic       ordered_q;
  logic [8:0] capacity_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ordered_q  <= 1'b1;
      capacity_q <= 9'd256;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[2]))
        REG_ORDERED:  ordered_q  <= pwdata[0];
        REG_CAPACITY: capacity_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_ORDERED:  prdata = {31'd0, ordered_q};
      REG_CAPACITY: prdata = {23'd0, capacity_q};
      default:      prdata = 32'd0;
    endcase
  end

  // limit is capacity saturated to the RAM depth
  logic [CNT_W-1:0] limit;
  assign limit = ({1'b0, capacity_q} > 10'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_q);

  // record RAM
  rec_t             mem_q [DEPTH];
  rec_t             rd_q;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  rec_t             wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // sequencer state
  state_e           state_q, state_d;
  func_e            func_q, func_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             sorted_q, sorted_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  rec_t             tmp_q, tmp_d;
  logic             valid_q, valid_d;
  logic [2:0]       status_q, status_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [PAY_W-1:0] fpay_q, fpay_d;
  logic [CNT_W-1:0] cnt_out_q, cnt_out_d;
  logic [CNT_W-1:0] mid_c;

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = valid_q;
  assign status_o          = status_q;
  assign index_o           = idx_q[7:0];
  assign found_payload_o   = fpay_q;
  assign entry_count_out_o = 9'(cnt_out_q);
  assign mid_c             = lo_q + ((hi_q - lo_q) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      sorted_q <= 1'b1;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sorted_q <= sorted_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    key_q     <= key_d;
    pay_q     <= pay_d;
    i_q       <= i_d;
    j_q       <= j_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    tmp_q     <= tmp_d;
    status_q  <= status_d;
    idx_q     <= idx_d;
    fpay_q    <= fpay_d;
    cnt_out_q <= cnt_out_d;
  end

  // next state, RAM control and result
  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    key_d     = key_q;
    pay_d     = pay_q;
    cnt_d     = cnt_q;
    sorted_d  = sorted_q;
    i_d       = i_q;
    j_d       = j_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    tmp_d     = tmp_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    idx_d     = idx_q;
    fpay_d    = fpay_q;
    cnt_out_d = cnt_out_q;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d   = func_e'(func_i);
          key_d    = key_i;
          pay_d    = payload_i;
          status_d = ST_OK;
          idx_d    = '0;
          fpay_d   = '0;
          i_d      = '0;
          lo_d     = '0;
          hi_d     = cnt_q;
          case (func_e'(func_i))
            FN_APPEND: begin
              if (cnt_q >= limit) begin
                status_d  = ST_FULL;
                valid_d   = 1'b1;
                cnt_out_d = cnt_q;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            FN_REMOVE, FN_SEQ: state_d = S_SCAN_RD;
            FN_SORT: begin
              i_d     = CNT_W'(1);
              state_d = S_SORT_RD_I;
            end
            FN_BIN: begin
              if (!sorted_q) begin
                status_d  = ST_UNSORTED;
                valid_d   = 1'b1;
                cnt_out_d = cnt_q;
              end else begin
                state_d = S_BIN_RD;
              end
            end
            default: begin
              valid_d   = 1'b1;
              cnt_out_d = cnt_q;
            end
          endcase
        end
      end

      // sequential scan for key
      S_SCAN_RD: begin
        raddr = i_q[IDX_W-1:0];
        if (i_q >= cnt_q) begin
          // key absent
          state_d = S_IDLE;
          valid_d = 1'b1;
          if (func_q == FN_APPEND) begin
            we        = 1'b1;
            waddr     = cnt_q[IDX_W-1:0];
            wdata     = '{key: key_q, pay: pay_q};
            idx_d     = cnt_q;
            cnt_d     = cnt_q + 1'b1;
            sorted_d  = 1'b0;
            cnt_out_d = cnt_q + 1'b1;
          end else begin
            status_d  = ST_NOT_FOUND;
            cnt_out_d = cnt_q;
          end
        end else begin
          state_d = S_SCAN_CK;
        end
      end

      S_SCAN_CK: begin
        if (rd_q.key == key_q) begin
          case (func_q)
            FN_APPEND: begin
              status_d  = ST_DUP;
              valid_d   = 1'b1;
              cnt_out_d = cnt_q;
              state_d   = S_IDLE;
            end
            FN_REMOVE: begin
              idx_d  = i_q;
              fpay_d = rd_q.pay;
              j_d    = i_q;
              if (ordered_q) begin
                state_d = S_SHIFT_RD;
              end else if (i_q != cnt_q - 1'b1) begin
                state_d = S_MOVE_RD;
              end else begin
                cnt_d     = cnt_q - 1'b1;
                cnt_out_d = cnt_q - 1'b1;
                valid_d   = 1'b1;
                state_d   = S_IDLE;
              end
            end
            default: begin
              idx_d     = i_q;
              fpay_d    = rd_q.pay;
              cnt_out_d = cnt_q;
              valid_d   = 1'b1;
              state_d   = S_IDLE;
            end
          endcase
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end

      // ordered remove: shift later entries down
      S_SHIFT_RD: begin
        raddr = IDX_W'(j_q + 1'b1);
        if (j_q + 1'b1 < cnt_q) begin
          state_d = S_SHIFT_WR;
        end else begin
          cnt_d     = cnt_q - 1'b1;
          cnt_out_d = cnt_q - 1'b1;
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_SHIFT_WR: begin
        we      = 1'b1;
        waddr   = j_q[IDX_W-1:0];
        wdata   = rd_q;
        j_d     = j_q + 1'b1;
        state_d = S_SHIFT_RD;
      end

      // unordered remove: last entry fills the gap
      S_MOVE_RD: begin
        raddr   = IDX_W'(cnt_q - 1'b1);
        state_d = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        we        = 1'b1;
        waddr     = j_q[IDX_W-1:0];
        wdata     = rd_q;
        sorted_d  = 1'b0;
        cnt_d     = cnt_q - 1'b1;
        cnt_out_d = cnt_q - 1'b1;
        valid_d   = 1'b1;
        state_d   = S_IDLE;
      end

      // binary search over [lo, hi)
      S_BIN_RD: begin
        raddr = mid_c[IDX_W-1:0];
        mid_d = mid_c;
        if (lo_q >= hi_q) begin
          status_d  = ST_NOT_FOUND;
          cnt_out_d = cnt_q;
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_BIN_CK;
        end
      end

      S_BIN_CK: begin
        state_d = S_BIN_RD;
        if (rd_q.key == key_q) begin
          idx_d     = mid_q;
          fpay_d    = rd_q.pay;
          cnt_out_d = cnt_q;
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end else if (rd_q.key < key_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
      end

      // insertion sort: pick entry i, sink it toward the front
      S_SORT_RD_I: begin
        raddr = i_q[IDX_W-1:0];
        if (i_q >= cnt_q) begin
          sorted_d  = 1'b1;
          cnt_out_d = cnt_q;
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_SORT_GET_I;
        end
      end

      S_SORT_GET_I: begin
        tmp_d   = rd_q;
        j_d     = i_q;
        state_d = S_SORT_RD_J;
      end

      S_SORT_RD_J: begin
        raddr = IDX_W'(j_q - 1'b1);
        if (j_q == '0) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = tmp_q;
          i_d     = i_q + 1'b1;
          state_d = S_SORT_RD_I;
        end else begin
          state_d = S_SORT_CK_J;
        end
      end

      S_SORT_CK_J: begin
        we    = 1'b1;
        waddr = j_q[IDX_W-1:0];
        if (rd_q.key > tmp_q.key) begin
          wdata   = rd_q;
          j_d     = j_q - 1'b1;
          state_d = S_SORT_RD_J;
        end else begin
          wdata   = tmp_q;
          i_d     = i_q + 1'b1;
          state_d = S_SORT_RD_I;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule
